// ----- design/mexp_pkg.sv -----
// Shared widths, request and response types, controller states and command/status groups.
package mexp_pkg;

    localparam int BASE_W = 63;
    localparam int EXP_W  = 63;
    localparam int MOD_W  = 32;
    localparam int CNT_W  = 6;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        logic [MOD_W-1:0]  modulus;
    } t_req;

    typedef struct packed {
        logic [MOD_W-1:0] power_mod;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_INIT,
        ST_SCAN,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic red_step;
        logic init;
        logic start_mul;
        logic start_sqr;
        logic mul_step;
        logic wb_acc;
        logic wb_sq;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic red_last;
        logic mul_last;
    } t_dp_sts;

endpackage

// ----- design/mexp_stream_if.sv -----
// Valid/ready channel carrying one request or response payload.
interface mexp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/mexp_ctrl.sv -----
// Sequencing state machine for reduction, multiply and square passes.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.mod_zero || i_sts.exp_zero) begin
                    n_state = ST_DONE;
                end else if (i_sts.exp_lsb) begin
                    o_cmd.start_mul = 1'b1;
                    n_state         = ST_MUL;
                end else begin
                    o_cmd.start_sqr = 1'b1;
                    n_state         = ST_SQR;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    o_cmd.wb_acc    = 1'b1;
                    o_cmd.start_sqr = 1'b1;
                    n_state         = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    o_cmd.wb_sq = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.capture = 1'b1;
                    n_rsp_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

    a_accept_starts_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == ST_REDUCE))
        else $error("accepted request did not start base reduction");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!r_rsp_valid || i_rsp_ready)) |=>
        (r_rsp_valid && r_state == ST_IDLE))
        else $error("finished result not presented");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.red_step, o_cmd.init, o_cmd.start_mul, o_cmd.capture}))
        else $error("conflicting datapath commands");

endmodule

// ----- design/mexp_dp.sv -----
// Operand registers and the shared shift-add-reduce step unit.
module mexp_dp
    import mexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic [MOD_W-1:0] o_power_mod
);

    logic [BASE_W-1:0] r_base, n_base;
    logic [EXP_W-1:0]  r_exp,  n_exp;
    logic [MOD_W-1:0]  r_mod,  n_mod;
    logic [MOD_W-1:0]  r_rem,  n_rem;
    logic [MOD_W-1:0]  r_acc,  n_acc;
    logic [MOD_W-1:0]  r_sq,   n_sq;
    logic [MOD_W-1:0]  r_ma,   n_ma;
    logic [MOD_W-1:0]  r_mb,   n_mb;
    logic [MOD_W-1:0]  r_out,  n_out;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    logic [MOD_W-1:0] addend;
    logic [MOD_W+1:0] t_sum;
    logic [MOD_W+2:0] d_one;
    logic [MOD_W+2:0] d_two;
    logic [MOD_W-1:0] step;

    always_comb begin
        if (i_cmd.red_step) begin
            addend = {{(MOD_W-1){1'b0}}, r_base[BASE_W-1]};
        end else begin
            addend = r_mb[MOD_W-1] ? r_ma : '0;
        end
        t_sum = {1'b0, r_rem, 1'b0} + {2'b00, addend};
        d_one = {1'b0, t_sum} - {3'b000, r_mod};
        d_two = {1'b0, t_sum} - {2'b00, r_mod, 1'b0};
        if (!d_two[MOD_W+2]) begin
            step = d_two[MOD_W-1:0];
        end else if (!d_one[MOD_W+2]) begin
            step = d_one[MOD_W-1:0];
        end else begin
            step = t_sum[MOD_W-1:0];
        end
    end

    always_comb begin
        n_base = r_base;
        n_exp  = r_exp;
        n_mod  = r_mod;
        n_rem  = r_rem;
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_out  = r_out;
        n_cnt  = r_cnt;
        if (i_cmd.load) begin
            n_base = i_req.base;
            n_exp  = i_req.exponent;
            n_mod  = i_req.modulus;
            n_rem  = '0;
            n_cnt  = '0;
        end
        if (i_cmd.red_step) begin
            n_rem  = step;
            n_base = {r_base[BASE_W-2:0], 1'b0};
            n_cnt  = r_cnt + CNT_W'(1);
        end
        if (i_cmd.init) begin
            n_sq  = r_rem;
            n_acc = (r_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
        end
        if (i_cmd.mul_step) begin
            n_rem = step;
            n_mb  = {r_mb[MOD_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (i_cmd.wb_acc) begin
            n_acc = step;
        end
        if (i_cmd.wb_sq) begin
            n_sq  = step;
            n_exp = {1'b0, r_exp[EXP_W-1:1]};
        end
        if (i_cmd.start_mul) begin
            n_ma  = r_sq;
            n_mb  = r_acc;
            n_rem = '0;
            n_cnt = '0;
        end
        if (i_cmd.start_sqr) begin
            n_ma  = r_sq;
            n_mb  = r_sq;
            n_rem = '0;
            n_cnt = '0;
        end
        if (i_cmd.capture) begin
            n_out = (r_mod == '0) ? '0 : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_exp  <= n_exp;
        r_mod  <= n_mod;
        r_rem  <= n_rem;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_out  <= n_out;
        r_cnt  <= n_cnt;
    end

    assign o_sts.mod_zero = (r_mod == '0);
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_sts.red_last = (r_cnt == CNT_W'(BASE_W - 1));
    assign o_sts.mul_last = (r_cnt == CNT_W'(MOD_W - 1));
    assign o_power_mod    = r_out;

    a_step_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.red_step || i_cmd.mul_step) && r_mod != '0 && $past(i_cmd.init) == 1'b0
         && r_rem < r_mod && r_ma < r_mod) |=> (r_rem < r_mod))
        else $error("step result not reduced below modulus");

    a_capture_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && r_mod == '0) |=> (r_out == '0))
        else $error("zero modulus must give zero result");

endmodule

// ----- design/modular_exponentiation_core.sv -----
// Top level: right-to-left square and multiply modular exponentiation.
//
//   channel | dir | payload                      | handshake
//   i_req   | in  | base, exponent, modulus      | valid/ready
//   o_rsp   | out | power_mod                    | valid/ready
//
// Each exponent bit up to the highest set bit costs one square, and each set bit a multiply
// before it. The next request is taken in the cycle the result appears. One bit-serial
// shift-add-reduce unit does the base reduction (63 steps) and every product (32 steps each).
// Reset clears the controller only; the datapath has no reset and reloads its working
// registers for each request.
// A new request is taken while a finished result still waits in the output register;
// hold the next result until that one is taken.
module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mexp_stream_if.sink   i_req,
    mexp_stream_if.source o_rsp
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [MOD_W-1:0] power_mod;
    t_req             req;

    assign req = i_req.payload;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mexp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_power_mod (power_mod)
    );

    assign o_rsp.payload.power_mod = power_mod;

endmodule
